// ----- hdl/nsp_pkg.sv -----
package nsp_pkg;

	localparam int MaxSpk  = 8;
	localparam int SpkW    = 3;
	localparam int CfgIdxW = 4;
	localparam int PosW    = 48;
	localparam int SmpW    = 16;
	localparam int GainW   = 24;
	localparam int StepW   = 25;
	localparam int ProdW   = 32;
	localparam int DotW    = 34;
	localparam int MulW    = 41;
	localparam int OutLsb  = 23;

	localparam logic [GainW-1:0] GainOne = 24'h800000;

	localparam logic KindDir = 1'b0;
	localparam logic KindSmp = 1'b1;

	// one item walking down the cell row
	typedef struct packed {
		logic                   vld;
		logic                   kind;
		logic signed [SmpW-1:0] dir_x;
		logic signed [SmpW-1:0] dir_y;
		logic signed [SmpW-1:0] dir_z;
		logic signed [SmpW-1:0] smp;
	} tok_t;

	// running argmax handed from cell to cell
	typedef struct packed {
		logic [SpkW-1:0]        idx;
		logic signed [DotW-1:0] dot;
	} best_t;

	typedef struct packed {
		logic            we;
		logic [SpkW-1:0] idx;
		logic [PosW-1:0] data;
	} cfg_wr_t;

	// step reload once the nearest speaker is known
	typedef struct packed {
		logic            we;
		logic [SpkW-1:0] best;
	} commit_t;

endpackage

// ----- hdl/nsp_if.sv -----
interface nsp_in_if;
	logic                            valid;
	logic                            ready;
	logic                            kind;
	logic signed [nsp_pkg::SmpW-1:0] dir_x;
	logic signed [nsp_pkg::SmpW-1:0] dir_y;
	logic signed [nsp_pkg::SmpW-1:0] dir_z;
	logic signed [nsp_pkg::SmpW-1:0] sample_in;

	modport source (output valid, kind, dir_x, dir_y, dir_z, sample_in, input ready);
	modport sink (input valid, kind, dir_x, dir_y, dir_z, sample_in, output ready);
endinterface

interface nsp_out_if;
	logic                            valid;
	logic                            ready;
	logic signed [nsp_pkg::SmpW-1:0] out_0;
	logic signed [nsp_pkg::SmpW-1:0] out_1;
	logic signed [nsp_pkg::SmpW-1:0] out_2;
	logic signed [nsp_pkg::SmpW-1:0] out_3;
	logic signed [nsp_pkg::SmpW-1:0] out_4;
	logic signed [nsp_pkg::SmpW-1:0] out_5;
	logic signed [nsp_pkg::SmpW-1:0] out_6;
	logic signed [nsp_pkg::SmpW-1:0] out_7;

	modport source (output valid, out_0, out_1, out_2, out_3, out_4, out_5, out_6, out_7,
		input ready);
	modport sink (input valid, out_0, out_1, out_2, out_3, out_4, out_5, out_6, out_7,
		output ready);
endinterface

interface nsp_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [nsp_pkg::CfgIdxW-1:0]    index;
	logic [nsp_pkg::PosW-1:0]       data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/nearest_speaker_panner.sv -----
// Nearest-speaker panner. A direction beat (kind 0) picks the speaker whose
// configured unit vector has the largest dot product with the direction, lowest
// index on a tie, and reloads every speaker's gain step so that the gains ramp
// toward one for that speaker and zero for the rest over 2^CHUNK_LOG2 samples.
// A sample beat (kind 1) advances each gain, clamps it to [0, 1.0] and returns
// sample times gain for every speaker; outputs of speakers at or above
// NUM_SPEAKERS read zero. Each beat walks a row of NUM_SPEAKERS cells, one
// speaker per cell, one cell per cycle. After a beat is accepted the input
// stays not ready while it passes the feed register, the row and then the
// commit, so no new beat is taken until the last one is through. A finished
// sample result sits in an output register and the next beat is taken while
// it waits; a sample that finishes while that register is still full holds
// the row, and the input, until the waiting result is taken. The user must
// write speaker positions through the config port only while the block is
// idle (not enforced); indexes past the last speaker register are ignored.
module nearest_speaker_panner #(
	parameter int unsigned NUM_SPEAKERS = 8,
	parameter int unsigned CHUNK_LOG2   = 6
) (
	input  logic      clk,
	input  logic      arst_n,
	nsp_in_if.sink    src,
	nsp_out_if.source res,
	nsp_cfg_if.sink   cfg
);

	nsp_pkg::tok_t                   feed_q;
	nsp_pkg::tok_t                   chain [NUM_SPEAKERS+1];
	nsp_pkg::best_t                  bst [NUM_SPEAKERS+1];
	logic signed [nsp_pkg::SmpW-1:0] cell_out [nsp_pkg::MaxSpk];
	logic signed [nsp_pkg::SmpW-1:0] res_q [nsp_pkg::MaxSpk];
	logic [NUM_SPEAKERS:0]           tok_vld;
	nsp_pkg::cfg_wr_t                cfg_wr;
	nsp_pkg::commit_t                cmt;

	logic busy_q;
	logic fin_q;
	logic kind_q;
	logic res_valid_q;
	logic accept;
	logic cmt_go;

	assign accept    = src.valid && src.ready;
	assign src.ready = !busy_q;
	assign cfg.ready = 1'b1;

	assign cfg_wr.we   = cfg.valid && (cfg.index < nsp_pkg::MaxSpk);
	assign cfg_wr.idx  = cfg.index[nsp_pkg::SpkW-1:0];
	assign cfg_wr.data = cfg.data;

	// a sample result must have room in the output register before it lands
	assign cmt_go   = fin_q && (kind_q == nsp_pkg::KindDir || !res_valid_q || res.ready);
	assign cmt.we   = cmt_go && kind_q == nsp_pkg::KindDir;
	assign cmt.best = bst[NUM_SPEAKERS].idx;

	assign chain[0] = feed_q;
	assign bst[0]   = '0;

	for (genvar k = 0; k < nsp_pkg::MaxSpk; k++) begin : g_spk
		if (k < NUM_SPEAKERS) begin : g_cell
			nsp_cell #(
				.Idx       (k),
				.ChunkLog2 (CHUNK_LOG2)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.tin     (chain[k]),
				.tout    (chain[k+1]),
				.bin     (bst[k]),
				.bout    (bst[k+1]),
				.cfg     (cfg_wr),
				.cmt     (cmt),
				.smp_out (cell_out[k])
			);
		end else begin : g_none
			assign cell_out[k] = '0;
		end
	end

	for (genvar k = 0; k <= NUM_SPEAKERS; k++) begin : g_vld
		assign tok_vld[k] = chain[k].vld;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feed_q      <= '0;
			busy_q      <= 1'b0;
			fin_q       <= 1'b0;
			kind_q      <= nsp_pkg::KindDir;
			res_valid_q <= 1'b0;
		end else begin
			feed_q.vld <= accept;
			if (accept) begin
				feed_q.kind  <= src.kind;
				feed_q.dir_x <= src.dir_x;
				feed_q.dir_y <= src.dir_y;
				feed_q.dir_z <= src.dir_z;
				feed_q.smp   <= src.sample_in;
				kind_q       <= src.kind;
				busy_q       <= 1'b1;
			end else if (cmt_go) begin
				busy_q <= 1'b0;
			end
			if (chain[NUM_SPEAKERS].vld) begin
				fin_q <= 1'b1;
			end else if (cmt_go) begin
				fin_q <= 1'b0;
			end
			if (cmt_go && kind_q == nsp_pkg::KindSmp) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmt_go && kind_q == nsp_pkg::KindSmp) begin
			res_q <= cell_out;
		end
	end

	assign res.valid = res_valid_q;
	assign res.out_0 = res_q[0];
	assign res.out_1 = res_q[1];
	assign res.out_2 = res_q[2];
	assign res.out_3 = res_q[3];
	assign res.out_4 = res_q[4];
	assign res.out_5 = res_q[5];
	assign res.out_6 = res_q[6];
	assign res.out_7 = res_q[7];

`ifndef SYNTHESIS
	a_one_beat_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_vld))
		else $error("more than one beat in the cell row");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q)
		else $error("block not busy after accepting a beat");

	a_fin_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |-> busy_q)
		else $error("row finished while block idle");

	a_result_posted: assert property (@(posedge clk) disable iff (!arst_n)
		(cmt_go && kind_q == nsp_pkg::KindSmp) |=> res.valid)
		else $error("sample beat finished without a result");
`endif

endmodule

// ----- hdl/nsp_cell.sv -----
module nsp_cell #(
	parameter int unsigned Idx       = 0,
	parameter int unsigned ChunkLog2 = 6
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  nsp_pkg::tok_t                   tin,
	output nsp_pkg::tok_t                   tout,
	input  nsp_pkg::best_t                  bin,
	output nsp_pkg::best_t                  bout,
	input  nsp_pkg::cfg_wr_t                cfg,
	input  nsp_pkg::commit_t                cmt,
	output logic signed [nsp_pkg::SmpW-1:0] smp_out
);

	localparam logic [nsp_pkg::SpkW-1:0] MyIdx = Idx[nsp_pkg::SpkW-1:0];

	logic [nsp_pkg::PosW-1:0]          pos_q;
	logic [nsp_pkg::GainW-1:0]         gain_q;
	logic signed [nsp_pkg::StepW-1:0]  step_q;
	nsp_pkg::tok_t                     stg_q;
	logic signed [nsp_pkg::ProdW-1:0]  px_q;
	logic signed [nsp_pkg::ProdW-1:0]  py_q;
	logic signed [nsp_pkg::ProdW-1:0]  pz_q;
	nsp_pkg::best_t                    bout_q;
	logic signed [nsp_pkg::SmpW-1:0]   out_q;

	logic signed [nsp_pkg::StepW:0]    gain_sum;
	logic [nsp_pkg::GainW-1:0]         gain_nxt;
	logic signed [nsp_pkg::DotW-1:0]   dot;
	logic                              take;
	logic signed [nsp_pkg::MulW-1:0]   prod;
	logic [nsp_pkg::StepW-1:0]         tgt;
	logic signed [nsp_pkg::StepW-1:0]  diff;

	always_comb begin
		gain_sum = $signed({2'b00, gain_q}) + $signed({step_q[nsp_pkg::StepW-1], step_q});
		if (gain_sum < 0) begin
			gain_nxt = '0;
		end else if (gain_sum > $signed({2'b00, nsp_pkg::GainOne})) begin
			gain_nxt = nsp_pkg::GainOne;
		end else begin
			gain_nxt = gain_sum[nsp_pkg::GainW-1:0];
		end
	end

	assign dot  = nsp_pkg::DotW'(px_q) + nsp_pkg::DotW'(py_q) + nsp_pkg::DotW'(pz_q);
	// strict compare keeps the lowest index on a tie
	assign take = (Idx == 0) || (dot > bin.dot);
	assign prod = stg_q.smp * $signed({1'b0, gain_q});
	assign tgt  = (cmt.best == MyIdx) ? {1'b0, nsp_pkg::GainOne} : '0;
	assign diff = $signed(tgt) - $signed({1'b0, gain_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			gain_q <= '0;
			step_q <= '0;
			stg_q  <= '0;
			bout_q <= '0;
		end else begin
			if (cfg.we && cfg.idx == MyIdx) begin
				pos_q <= cfg.data;
			end
			stg_q.vld <= tin.vld;
			if (tin.vld) begin
				stg_q.kind  <= tin.kind;
				stg_q.dir_x <= tin.dir_x;
				stg_q.dir_y <= tin.dir_y;
				stg_q.dir_z <= tin.dir_z;
				stg_q.smp   <= tin.smp;
				if (tin.kind == nsp_pkg::KindSmp) begin
					gain_q <= gain_nxt;
				end
			end
			if (stg_q.vld && stg_q.kind == nsp_pkg::KindDir && take) begin
				bout_q.idx <= MyIdx;
				bout_q.dot <= dot;
			end else if (stg_q.vld && stg_q.kind == nsp_pkg::KindDir) begin
				bout_q <= bin;
			end
			if (cmt.we) begin
				step_q <= diff >>> ChunkLog2;
			end
		end
	end

	// products and output carry no reset
	always_ff @(posedge clk) begin
		if (tin.vld && tin.kind == nsp_pkg::KindDir) begin
			px_q <= $signed(pos_q[15:0]) * tin.dir_x;
			py_q <= $signed(pos_q[31:16]) * tin.dir_y;
			pz_q <= $signed(pos_q[47:32]) * tin.dir_z;
		end
		if (stg_q.vld && stg_q.kind == nsp_pkg::KindSmp) begin
			out_q <= prod[nsp_pkg::OutLsb+nsp_pkg::SmpW-1:nsp_pkg::OutLsb];
		end
	end

	assign tout    = stg_q;
	assign bout    = bout_q;
	assign smp_out = out_q;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

	localparam int NumSpk      = 8;
	localparam int ChunkLog2   = 6;
	localparam int PhaseItems  = 275;
	localparam int DrainCycles = 40;
	localparam int LongHold    = 300;

	typedef logic [nsp_pkg::MaxSpk-1:0][nsp_pkg::SmpW-1:0] mix_t;

	typedef enum int {LayoutAxes, LayoutOnes, LayoutRandom, LayoutZero, LayoutCorners} layout_e;
	typedef enum int {RxOpen, RxCoin, RxComb} rx_mode_e;

	typedef struct packed {
		logic                            kind;
		logic signed [nsp_pkg::SmpW-1:0] dx;
		logic signed [nsp_pkg::SmpW-1:0] dy;
		logic signed [nsp_pkg::SmpW-1:0] dz;
		logic signed [nsp_pkg::SmpW-1:0] smp;
		logic                            typed;
		mix_t                            want;
	} plan_row_t;

	// speaker layout during the directed part: +x -x +y -y +z -z, a copy of +y
	// (tie with speaker 2), and a diagonal
	localparam plan_row_t Plan [23] = '{
		'{nsp_pkg::KindSmp, 16'sd0, 16'sd0, 16'sd0, 16'sh7FFF, 1'b1, '0},
		'{nsp_pkg::KindSmp, 16'sd0, 16'sd0, 16'sd0, 16'sh8000, 1'b1, '0},
		'{nsp_pkg::KindDir, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, '0},
		'{nsp_pkg::KindSmp, 16'sd0, 16'sd0, 16'sd0, 16'sh7FFF, 1'b0, '0},
		'{nsp_pkg::KindSmp, 16'sd0, 16'sd0, 16'sd0, 16'sh8000, 1'b0, '0},
		'{nsp_pkg::KindSmp, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, '0},
		'{nsp_pkg::KindSmp, 16'sd0, 16'sd0, 16'sd0, -16'sd1, 1'b0, '0},
		'{nsp_pkg::KindDir, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sd0, 1'b0, '0},
		'{nsp_pkg::KindSmp, 16'sd0, 16'sd0, 16'sd0, 16'sh7FFF, 1'b0, '0},
		'{nsp_pkg::KindDir, 16'sh8000, 16'sh8000, 16'sh8000, 16'sd0, 1'b0, '0},
		'{nsp_pkg::KindSmp, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 1'b0, '0},
		'{nsp_pkg::KindDir, 16'sd0, 16'sd1000, 16'sd0, 16'sd0, 1'b0, '0},
		'{nsp_pkg::KindSmp, 16'sd0, 16'sd0, 16'sd0, 16'sh7FFF, 1'b0, '0},
		'{nsp_pkg::KindDir, 16'sd0, 16'sd0, 16'sh8000, 16'sd0, 1'b0, '0},
		'{nsp_pkg::KindSmp, 16'sd0, 16'sd0, 16'sd0, 16'sh8000, 1'b0, '0},
		'{nsp_pkg::KindDir, 16'sh8000, 16'sh7FFF, -16'sd1, 16'sd0, 1'b0, '0},
		'{nsp_pkg::KindSmp, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sd16384, 1'b0, '0},
		'{nsp_pkg::KindSmp, 16'sd0, 16'sd0, 16'sd0, -16'sd12345, 1'b0, '0},
		'{nsp_pkg::KindDir, 16'sd0, 16'sd0, 16'sd0, 16'sh7FFF, 1'b0, '0},
		'{nsp_pkg::KindSmp, 16'sd0, 16'sd0, 16'sd0, 16'sh7FFF, 1'b0, '0},
		'{nsp_pkg::KindSmp, 16'sd0, 16'sd0, 16'sd0, 16'sh8000, 1'b0, '0},
		'{nsp_pkg::KindDir, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sd0, 1'b0, '0},
		'{nsp_pkg::KindSmp, 16'sd0, 16'sd0, 16'sd0, 16'sd7, 1'b0, '0}
	};

	localparam layout_e PhaseLayout [6] = '{
		LayoutAxes, LayoutOnes, LayoutRandom, LayoutZero, LayoutCorners, LayoutRandom
	};

	logic clk = 1'b0;
	logic arst_n;

	nsp_in_if  src ();
	nsp_out_if res ();
	nsp_cfg_if cfg ();

	nearest_speaker_panner #(
		.NUM_SPEAKERS(NumSpk),
		.CHUNK_LOG2  (ChunkLog2)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.src   (src),
		.res   (res),
		.cfg   (cfg)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#5ms;
		$display("Mismatches found");
		$finish;
	end

	// panner state as the block should hold it
	logic [nsp_pkg::PosW-1:0]         spk_pos  [nsp_pkg::MaxSpk];
	logic [nsp_pkg::GainW-1:0]        gain_lvl [nsp_pkg::MaxSpk];
	logic signed [nsp_pkg::StepW-1:0] gain_inc [nsp_pkg::MaxSpk];

	mix_t pending_mix [$];
	int   mismatches;
	int   mix_beats;
	int   burst_left;
	bit   hold_req;

	function automatic longint spk_dot(int k, logic signed [nsp_pkg::SmpW-1:0] x, y, z);
		logic signed [nsp_pkg::SmpW-1:0] px, py, pz;
		px = spk_pos[k][15:0];
		py = spk_pos[k][31:16];
		pz = spk_pos[k][47:32];
		return longint'(px) * longint'(x) + longint'(py) * longint'(y)
			+ longint'(pz) * longint'(z);
	endfunction

	function automatic void pan_direction(logic signed [nsp_pkg::SmpW-1:0] x, y, z);
		int     best;
		longint best_dot, d;
		int     diff;
		best = 0;
		best_dot = spk_dot(0, x, y, z);
		for (int k = 1; k < NumSpk; k++) begin
			d = spk_dot(k, x, y, z);
			if (d > best_dot) begin
				best_dot = d;
				best = k;
			end
		end
		for (int k = 0; k < NumSpk; k++) begin
			diff = ((k == best) ? int'(nsp_pkg::GainOne) : 0) - int'(gain_lvl[k]);
			gain_inc[k] = nsp_pkg::StepW'(diff >>> ChunkLog2);
		end
	endfunction

	function automatic void mix_sample(input logic signed [nsp_pkg::SmpW-1:0] smp,
		output mix_t mix);
		int     g;
		longint p;
		mix = '0;
		for (int k = 0; k < NumSpk; k++) begin
			g = int'(gain_lvl[k]) + int'(gain_inc[k]);
			if (g < 0)
				g = 0;
			if (g > int'(nsp_pkg::GainOne))
				g = int'(nsp_pkg::GainOne);
			gain_lvl[k] = nsp_pkg::GainW'(g);
			p = (longint'(smp) * longint'(g)) >>> nsp_pkg::OutLsb;
			mix[k] = p[nsp_pkg::SmpW-1:0];
		end
	endfunction

	function automatic logic [nsp_pkg::PosW-1:0] layout_word(layout_e l, int k);
		logic [nsp_pkg::SmpW-1:0] hi, lo, dg, zr;
		hi = 16'h7FFF;
		lo = 16'h8000;
		dg = 16'h49E6;
		zr = '0;
		case (l)
			LayoutAxes: begin
				case (k)
					0: return {zr, zr, hi};
					1: return {zr, zr, lo};
					2: return {zr, hi, zr};
					3: return {zr, lo, zr};
					4: return {hi, zr, zr};
					5: return {lo, zr, zr};
					6: return {zr, hi, zr};
					default: return {dg, dg, dg};
				endcase
			end
			LayoutOnes: return '1;
			LayoutZero: return '0;
			LayoutCorners: return {k[2] ? lo : hi, k[1] ? lo : hi, k[0] ? lo : hi};
			default: return nsp_pkg::PosW'({$urandom, $urandom});
		endcase
	endfunction

	function automatic logic signed [nsp_pkg::SmpW-1:0] rand_word();
		case ($urandom_range(0, 9))
			0: return 16'sd0;
			1: return 16'sh7FFF;
			2: return 16'sh8000;
			3: return nsp_pkg::SmpW'(int'($urandom_range(0, 6)) - 3);
			default: return nsp_pkg::SmpW'($urandom);
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] result %0d: %s", $realtime, mix_beats, msg);
		mismatches++;
	endtask

	task automatic write_reg(input int idx, input logic [nsp_pkg::PosW-1:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= nsp_pkg::CfgIdxW'(idx);
		cfg.data  <= data;
		do @(posedge clk); while (cfg.ready !== 1'b1);
		if (idx < nsp_pkg::MaxSpk)
			spk_pos[idx] = data;
		@(negedge clk);
	endtask

	task automatic load_layout(input layout_e l);
		for (int k = 0; k < nsp_pkg::MaxSpk; k++)
			write_reg(k, layout_word(l, k));
		// index past the last speaker: must leave every position alone
		write_reg($urandom_range(nsp_pkg::MaxSpk, 2 ** nsp_pkg::CfgIdxW - 1),
			nsp_pkg::PosW'({$urandom, $urandom}));
		cfg.valid <= 1'b0;
	endtask

	task automatic push(input logic kind, input logic signed [nsp_pkg::SmpW-1:0] dx, dy, dz,
		smp, input logic typed, input mix_t want);
		mix_t pred;
		int   gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = $urandom_range(1, 40);
			if (gap > 0) begin
				src.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		src.valid     <= 1'b1;
		src.kind      <= kind;
		src.dir_x     <= dx;
		src.dir_y     <= dy;
		src.dir_z     <= dz;
		src.sample_in <= smp;
		do @(posedge clk); while (src.ready !== 1'b1);
		if (kind == nsp_pkg::KindDir) begin
			pan_direction(dx, dy, dz);
		end else begin
			mix_sample(smp, pred);
			pending_mix.push_back(typed ? want : pred);
		end
		@(negedge clk);
	endtask

	task automatic push_random(input logic kind);
		logic signed [nsp_pkg::SmpW-1:0] x, y, z;
		if (kind == nsp_pkg::KindDir && $urandom_range(0, 19) == 0) begin
			x = '0;
			y = '0;
			z = '0;
		end else begin
			x = rand_word();
			y = rand_word();
			z = rand_word();
		end
		push(kind, x, y, z, rand_word(), 1'b0, '0);
	endtask

	// wait out every pending result, then the tail of a direction beat
	task automatic settle();
		src.valid <= 1'b0;
		while (pending_mix.size() != 0)
			@(negedge clk);
		repeat (DrainCycles) @(negedge clk);
	endtask

	always @(posedge clk) begin : check_mix
		mix_t got, want;
		if (arst_n && res.valid === 1'b1 && res.ready === 1'b1) begin
			got = {res.out_7, res.out_6, res.out_5, res.out_4,
				res.out_3, res.out_2, res.out_1, res.out_0};
			if (pending_mix.size() == 0) begin
				report_mismatch("result beat with nothing pending");
			end else begin
				want = pending_mix.pop_front();
				for (int k = 0; k < nsp_pkg::MaxSpk; k++)
					if (got[k] !== want[k])
						report_mismatch($sformatf("out_%0d: got %0d, expected %0d",
							k, $signed(got[k]), $signed(want[k])));
			end
			mix_beats++;
		end
	end

	// output back-pressure; a long hold on request fills the block up
	initial begin
		rx_mode_e mode;
		int       mode_left, hold_left, tick;
		res.ready = 1'b0;
		mode = RxOpen;
		mode_left = 0;
		hold_left = 0;
		tick = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			tick++;
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = LongHold;
			end
			if (hold_left > 0) begin
				hold_left--;
				res.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = rx_mode_e'($urandom_range(0, 2));
					mode_left = $urandom_range(20, 300);
				end
				mode_left--;
				case (mode)
					RxOpen: res.ready <= 1'b1;
					RxCoin: res.ready <= 1'($urandom_range(0, 1));
					default: res.ready <= (tick % 5) >= 3;
				endcase
			end
		end
	end

	initial begin
		int done, n;
		bit pressed;
		src.valid = 1'b0;
		src.kind = nsp_pkg::KindDir;
		src.dir_x = '0;
		src.dir_y = '0;
		src.dir_z = '0;
		src.sample_in = '0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		arst_n = 1'b0;
		mismatches = 0;
		mix_beats = 0;
		burst_left = 0;
		hold_req = 1'b0;
		pressed = 1'b0;
		for (int k = 0; k < nsp_pkg::MaxSpk; k++) begin
			spk_pos[k] = '0;
			gain_lvl[k] = '0;
			gain_inc[k] = '0;
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int ph = 0; ph < 6; ph++) begin
			if (ph > 0)
				settle();
			load_layout(PhaseLayout[ph]);
			if (ph == 0)
				foreach (Plan[i])
					push(Plan[i].kind, Plan[i].dx, Plan[i].dy, Plan[i].dz, Plan[i].smp,
						Plan[i].typed, Plan[i].want);
			done = 0;
			while (done < PhaseItems) begin
				if (ph == 2 && !pressed && done >= 40) begin
					hold_req = 1'b1;
					pressed = 1'b1;
				end
				if ($urandom_range(0, 99) < 85) begin
					// a chunk: direction, then a ramp of samples
					push_random(nsp_pkg::KindDir);
					done++;
					n = ($urandom_range(0, 9) == 0) ? $urandom_range(65, 140)
						: $urandom_range(1, 64);
					repeat (n) begin
						push_random(nsp_pkg::KindSmp);
						done++;
					end
				end else begin
					push_random(1'($urandom_range(0, 1)));
					done++;
				end
			end
		end
		settle();

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/nsp_pkg.sv
hdl/nsp_if.sv
hdl/nsp_cell.sv
hdl/nearest_speaker_panner.sv
tb/testbench.sv
